FILE: rtl/idpa_pkg.sv
package idpa_pkg;

   // command codes
   localparam logic [2:0] CMD_CHECK     = 3'd0;
   localparam logic [2:0] CMD_CLAIM     = 3'd1;
   localparam logic [2:0] CMD_PEEK      = 3'd2;
   localparam logic [2:0] CMD_CLAIM_LOW = 3'd3;
   localparam logic [2:0] CMD_CLEAR     = 3'd4;

   // status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_TAKEN   = 2'd1;
   localparam logic [1:0] STS_RANGE   = 2'd2;
   localparam logic [1:0] STS_NO_FREE = 2'd3;

   // register indexes
   localparam logic [0:0] CSR_RANGE_START = 1'b0;
   localparam logic [0:0] CSR_RANGE_END   = 1'b1;

   localparam logic [15:0] RANGE_END_RESET = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] result_id;
      logic        is_free;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM_RD,
      ST_SUM_CHK,
      ST_MAP_CHK,
      ST_POST,
      ST_ID_CHK,
      ST_SU_CHK,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/idpa_ram.sv
module idpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/id_pool_allocator_core.sv
// search path: the accept issues the summary read, then ST_SUM_CHK, ST_MAP_CHK and
//   ST_POST (ST_ID_CHK, ST_SU_CHK where needed) to ST_DONE; a further summary word
//   adds ST_SUM_RD and ST_SUM_CHK; the summary ram is walked one word at a time
// throughput: one item at a time; the next item is taken once the result is queued
// clear command and reset: one map word cleared per cycle, over all 2^(ID_BITS-6) words
// reset: synchronous; the clearing pass runs right after reset with req_stall high
module id_pool_allocator_core #(
   parameter int ID_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  idpa_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output idpa_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   import idpa_pkg::*;

   // word index into the used map, summary sizing
   localparam int WAW       = ID_BITS - 6;
   localparam int MAP_WORDS = 1 << WAW;
   localparam int SUM_WORDS = (MAP_WORDS + 63) / 64;
   localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
   localparam int SUM_DEPTH = 1 << SUM_AW;
   // compare width for ids and range bounds
   localparam int XW = (ID_BITS > 16) ? ID_BITS : 16;
   localparam logic [XW-1:0] MAX_ID = XW'((64'd1 << ID_BITS) - 64'd1);
   localparam logic [63:0]   ONES   = {64{1'b1}};

   function automatic logic [5:0] lowest_bit(input logic [63:0] v);
      logic [5:0] r;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         if (v[i]) begin
            r = 6'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [SUM_AW-1:0] sum_idx(input logic [WAW-1:0] w);
      logic [WAW-1:0] sh;
      sh = w >> 6;
      return sh[SUM_AW-1:0];
   endfunction

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [15:0]        range_start_ff, range_end_ff;
   req_type            item_ff, item_in;
   logic [WAW-1:0]     wp_ff, wp_in;       // lowest word still to search
   logic [WAW-1:0]     w_ff, w_in;         // candidate or target map word
   logic [63:0]        word_ff, word_in;   // map word holding the found id
   logic               found_ff, found_in;
   logic [ID_BITS-1:0] low_ff, low_in;
   rsp_type            res_ff, res_in;     // result waiting for the output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [WAW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic               clr_rsp_ff, clr_rsp_in;

   // ------------------------------------------------------------------
   // memories: used map and per-word full summary
   // ------------------------------------------------------------------
   logic              map_we;
   logic [WAW-1:0]    map_waddr, map_raddr;
   logic [63:0]       map_wdata, map_rdata;
   logic              sum_we;
   logic [SUM_AW-1:0] sum_waddr, sum_raddr;
   logic [63:0]       sum_wdata, sum_rdata;

   idpa_ram #(.WIDTH(64), .DEPTH(MAP_WORDS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   idpa_ram #(.WIDTH(64), .DEPTH(SUM_DEPTH)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_addr (sum_raddr),
      .rd_data (sum_rdata)
   );

   // ------------------------------------------------------------------
   // range decode; the user must keep config stable while an item is in flight (no check in the block)
   // ------------------------------------------------------------------
   logic [XW-1:0]  s_x, e_raw, e_x, id_x;
   logic           pool_empty, id_inr;
   logic [WAW-1:0] ws, we, id_w;

   assign s_x        = XW'(range_start_ff);
   assign e_raw      = XW'(range_end_ff);
   assign e_x        = (e_raw > MAX_ID) ? MAX_ID : e_raw;
   assign pool_empty = s_x > e_x;
   assign ws         = WAW'(s_x >> 6);
   assign we         = WAW'(e_x >> 6);
   assign id_x       = XW'(item_ff.id);
   assign id_inr     = (id_x >= s_x) && (id_x <= e_x);
   assign id_w       = WAW'(id_x >> 6);

   // summary scan: non-full words of the current summary word within bounds
   logic [SUM_AW-1:0] si_cur;
   logic              si_last;
   logic [5:0]        sum_lo, sum_hi, cand_bit;
   logic [63:0]       cand;
   logic              cand_any;
   logic [WAW-1:0]    cand_w, wp_skip;

   assign si_cur   = sum_idx(wp_ff);
   assign si_last  = si_cur == sum_idx(we);
   assign sum_lo   = 6'(wp_ff);
   assign sum_hi   = si_last ? 6'(we) : 6'd63;
   assign cand     = ~sum_rdata & (ONES << sum_lo) & (ONES >> (6'd63 - sum_hi));
   assign cand_any = |cand;
   assign cand_bit = lowest_bit(cand);
   assign cand_w   = WAW'({si_cur, cand_bit});
   assign wp_skip  = WAW'({SUM_AW'(si_cur + 1'b1), 6'd0});

   // map word check: free bits clipped to the range at both ends
   logic [63:0] free_bits;
   logic        free_any;
   logic [5:0]  free_bit;

   always_comb begin
      free_bits = ~map_rdata;
      if (w_ff == ws) begin
         free_bits = free_bits & (ONES << 6'(s_x));
      end
      if (w_ff == we) begin
         free_bits = free_bits & (ONES >> (6'd63 - 6'(e_x)));
      end
   end

   assign free_any = |free_bits;
   assign free_bit = lowest_bit(free_bits);

   // word updates for the two claim commands
   logic [63:0] low_word_new, id_word_new;
   logic        id_bit_used;

   assign low_word_new = word_ff | (64'd1 << low_ff[5:0]);
   assign id_word_new  = map_rdata | (64'd1 << item_ff.id[5:0]);
   assign id_bit_used  = map_rdata[item_ff.id[5:0]];

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == WAW'(MAP_WORDS - 1)) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd == CMD_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (req_data.cmd > CMD_CLEAR) begin
                  state_in = ST_DONE;
               end else if (pool_empty) begin
                  state_in = ST_POST;
               end else begin
                  state_in = ST_SUM_CHK;
               end
            end
         end
         ST_SUM_RD: state_in = ST_SUM_CHK;
         ST_SUM_CHK: begin
            if (cand_any) begin
               state_in = ST_MAP_CHK;
            end else if (si_last) begin
               state_in = ST_POST;
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_MAP_CHK: begin
            if (free_any || (w_ff == we)) begin
               state_in = ST_POST;
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_POST: begin
            case (item_ff.cmd)
               CMD_CHECK: state_in = (id_inr && found_ff) ? ST_ID_CHK : ST_DONE;
               CMD_CLAIM: state_in = (id_inr && found_ff) ? ST_ID_CHK : ST_DONE;
               CMD_CLAIM_LOW: begin
                  state_in = (found_ff && (low_word_new == ONES)) ? ST_SU_CHK : ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_ID_CHK: begin
            if ((item_ff.cmd == CMD_CLAIM) && !id_bit_used && (id_word_new == ONES)) begin
               state_in = ST_SU_CHK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SU_CHK: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // memory controls and datapath updates
   // ------------------------------------------------------------------
   always_comb begin
      item_in     = item_ff;
      wp_in       = wp_ff;
      w_in        = w_ff;
      word_in     = word_ff;
      found_in    = found_ff;
      low_in      = low_ff;
      res_in      = res_ff;
      clr_cnt_in  = clr_cnt_ff;
      clr_rsp_in  = clr_rsp_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      map_we      = 1'b0;
      map_waddr   = w_ff;
      map_wdata   = low_word_new;
      map_raddr   = cand_w;
      sum_we      = 1'b0;
      sum_waddr   = sum_idx(w_ff);
      sum_wdata   = sum_rdata | (64'd1 << 6'(w_ff));
      sum_raddr   = si_cur;

      unique case (state_ff)
         ST_CLEAR: begin
            map_we     = 1'b1;
            map_waddr  = clr_cnt_ff;
            map_wdata  = '0;
            sum_we     = 1'b1;
            sum_waddr  = clr_cnt_ff[SUM_AW-1:0];
            sum_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            // summary read for the start word goes out with the accept
            sum_raddr = sum_idx(ws);
            if (req_valid) begin
               item_in    = req_data;
               wp_in      = ws;
               found_in   = 1'b0;
               res_in     = '{status: STS_OK, result_id: req_data.id, is_free: 1'b0};
               clr_cnt_in = '0;
               clr_rsp_in = 1'b1;
            end
         end
         ST_SUM_RD: begin
            sum_raddr = si_cur;
         end
         ST_SUM_CHK: begin
            // map read of the first non-full word goes out now
            map_raddr = cand_w;
            w_in      = cand_w;
            if (!cand_any && !si_last) begin
               wp_in = wp_skip;
            end
         end
         ST_MAP_CHK: begin
            word_in = map_rdata;
            if (free_any) begin
               found_in = 1'b1;
               low_in   = {w_ff, free_bit};
            end else begin
               wp_in = w_ff + 1'b1;
            end
         end
         ST_POST: begin
            map_raddr = id_w;
            sum_raddr = sum_idx(w_ff);
            case (item_ff.cmd)
               CMD_CHECK: begin
                  if (!id_inr) begin
                     res_in.status = STS_RANGE;
                  end else if (!found_ff) begin
                     res_in.status = STS_NO_FREE;
                  end
               end
               CMD_CLAIM: begin
                  if (!found_ff) begin
                     res_in.status = STS_NO_FREE;
                  end else if (!id_inr) begin
                     res_in.status = STS_RANGE;
                  end
               end
               CMD_PEEK, CMD_CLAIM_LOW: begin
                  if (found_ff) begin
                     res_in = '{status: STS_OK, result_id: 16'(low_ff), is_free: 1'b1};
                     if (item_ff.cmd == CMD_CLAIM_LOW) begin
                        map_we    = 1'b1;
                        map_waddr = w_ff;
                        map_wdata = low_word_new;
                     end
                  end else begin
                     res_in = '{status: STS_NO_FREE, result_id: 16'd0, is_free: 1'b0};
                  end
               end
               default: res_in = res_ff;
            endcase
         end
         ST_ID_CHK: begin
            sum_raddr = sum_idx(id_w);
            w_in      = id_w;
            if (item_ff.cmd == CMD_CLAIM) begin
               if (id_bit_used) begin
                  res_in.status = STS_TAKEN;
               end else begin
                  res_in.is_free = 1'b1;
                  map_we         = 1'b1;
                  map_waddr      = id_w;
                  map_wdata      = id_word_new;
               end
            end else begin
               res_in.is_free = !id_bit_used;
            end
         end
         ST_SU_CHK: begin
            // word just became full: set its summary bit
            sum_we    = 1'b1;
            sum_waddr = sum_idx(w_ff);
            sum_wdata = sum_rdata | (64'd1 << 6'(w_ff));
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
            map_we = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // register update
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         range_start_ff <= '0;
         range_end_ff   <= RANGE_END_RESET;
         rsp_valid_ff   <= 1'b0;
         clr_cnt_ff     <= '0;
         clr_rsp_ff     <= 1'b0;
         found_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         found_ff     <= found_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_RANGE_START: range_start_ff <= csr_wdata;
               CSR_RANGE_END:   range_end_ff   <= csr_wdata;
               default:         range_end_ff   <= range_end_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      wp_ff       <= wp_in;
      w_ff        <= w_in;
      word_ff     <= word_in;
      low_ff      <= low_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // a found id always lies inside the configured range
   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST && found_ff) |-> (XW'(low_ff) >= s_x && XW'(low_ff) <= e_x))
      else $error("found id outside range");

   // a map write that fills a word is followed by the summary update
   a_full_word_summary: assert property (@(posedge clock) disable iff (reset)
      (map_we && map_wdata == ONES && state_ff != ST_CLEAR) |=> (state_ff == ST_SU_CHK))
      else $error("full map word without summary update");

   // the clearing pass writes zeros to both memories
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (map_we && sum_we && map_wdata == '0 && sum_wdata == '0))
      else $error("clearing pass wrote non-zero data");

   // the queued result is never overwritten while it waits
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("waiting result lost");
`endif

endmodule

FILE: sim/tb_id_pool_allocator_core.sv
`timescale 1ns / 100ps

module tb_id_pool_allocator_core;
   import idpa_pkg::*;

   // commands with no function, used to show that nothing changes
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

   // the worst search scans all 16 summary words
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASES        = 7;

   // one line of the directed script: a register write or a command item
   typedef struct packed {
      logic       csr;
      logic [0:0] reg_idx;
      logic [2:0] cmd;
      logic [15:0] val;
      logic       typed;
      rsp_type    want;
   } script_row;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // shadow of the used-id bitmap and the managed range
   logic [63:0] pool_map [1024] = '{default: '0};
   logic [15:0] range_lo = 16'h0000;
   logic [15:0] range_hi = RANGE_END_RESET;

   rsp_type alloc_expect [$];

   int req_idle_pct = 24;
   int rsp_idle_pct = 81;
   logic start_hold = 1'b0;
   logic long_hold = 1'b0;

   int mismatches = 0;
   int items_sent = 0;
   int csr_writes = 0;
   int status_seen [4] = '{default: 0};
   int unsigned cycle_count = 0;

   id_pool_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // lowest free id inside the range; a word that is all ones is exactly a word
   // whose summary bit is set, since bits are only ever set or all cleared
   function automatic bit lowest_free_id(output logic [15:0] found);
      logic [63:0] avail;
      found = '0;
      if (range_lo > range_hi) return 1'b0;
      for (int w = range_lo[15:6]; w <= range_hi[15:6]; w++) begin
         avail = ~pool_map[w];
         if (w == range_lo[15:6]) avail &= {64{1'b1}} << range_lo[5:0];
         if (w == range_hi[15:6]) avail &= {64{1'b1}} >> (6'd63 - range_hi[5:0]);
         if (avail != '0) begin
            for (int b = 0; b < 64; b++) begin
               if (avail[b]) begin
                  found = {w[9:0], b[5:0]};
                  return 1'b1;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   // expected result of one command, updating the shadow bitmap
   function automatic rsp_type predict_alloc(req_type r);
      rsp_type     o;
      logic [15:0] low;
      bit          in_rng;
      bit          taken;
      o.status    = STS_OK;
      o.result_id = r.id;
      o.is_free   = 1'b0;
      in_rng = (r.id >= range_lo) && (r.id <= range_hi);
      taken  = pool_map[r.id[15:6]][r.id[5:0]];
      case (r.cmd)
         CMD_CHECK: begin
            if (!in_rng) o.status = STS_RANGE;
            else if (!lowest_free_id(low)) o.status = STS_NO_FREE;
            else o.is_free = !taken;
         end
         CMD_CLAIM: begin
            // an empty pool wins over a bad or taken id
            if (!lowest_free_id(low)) o.status = STS_NO_FREE;
            else if (!in_rng) o.status = STS_RANGE;
            else if (taken) o.status = STS_TAKEN;
            else begin
               pool_map[r.id[15:6]][r.id[5:0]] = 1'b1;
               o.is_free = 1'b1;
            end
         end
         CMD_PEEK, CMD_CLAIM_LOW: begin
            if (lowest_free_id(low)) begin
               o.result_id = low;
               o.is_free   = 1'b1;
               if (r.cmd == CMD_CLAIM_LOW) pool_map[low[15:6]][low[5:0]] = 1'b1;
            end else begin
               o.status    = STS_NO_FREE;
               o.result_id = '0;
            end
         end
         CMD_CLEAR: begin
            foreach (pool_map[i]) pool_map[i] = '0;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic script_row known_row(logic [2:0] cmd, logic [15:0] id,
                                           logic [1:0] sts, logic [15:0] rid,
                                           logic fr);
      script_row row;
      row = '0;
      row.cmd = cmd;
      row.val = id;
      row.typed = 1'b1;
      row.want.status = sts;
      row.want.result_id = rid;
      row.want.is_free = fr;
      return row;
   endfunction

   function automatic script_row open_row(logic [2:0] cmd, logic [15:0] id);
      script_row row;
      row = '0;
      row.cmd = cmd;
      row.val = id;
      return row;
   endfunction

   function automatic script_row csr_row(logic [0:0] idx, logic [15:0] val);
      script_row row;
      row = '0;
      row.csr = 1'b1;
      row.reg_idx = idx;
      row.val = val;
      return row;
   endfunction

   // random command, ids mostly inside or just around the range
   function automatic req_type random_item();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 20) r.cmd = CMD_CHECK;
      else if (pick < 42) r.cmd = CMD_CLAIM;
      else if (pick < 52) r.cmd = CMD_PEEK;
      else if (pick < 92) r.cmd = CMD_CLAIM_LOW;
      else if (pick < 94) r.cmd = CMD_CLEAR;
      else r.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      pick = $urandom_range(99);
      if (range_lo <= range_hi && pick < 70) begin
         r.id = 16'($urandom_range(range_lo, range_hi));
      end else if (pick < 85) begin
         case ($urandom_range(3))
            0: r.id = range_lo - 16'd1;
            1: r.id = range_lo;
            2: r.id = range_hi;
            default: r.id = range_hi + 16'd1;
         endcase
      end else begin
         r.id = 16'($urandom);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d (%s): expected status %0d id %h free %0d, got status %0d id %h free %0d",
                  cycle_count, what, want.status, want.result_id, want.is_free,
                  got.status, got.result_id, got.is_free);
   endtask

   // hold the item until taken, then record what it should produce
   task automatic offer_item(req_type r, logic typed, rsp_type typed_rsp);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predicted = predict_alloc(r);
      alloc_expect.push_back(typed ? typed_rsp : predicted);
      items_sent++;
   endtask

   // random gap after an item; valid stays up when no gap is drawn
   task automatic sender_pause();
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // registers change only with the block idle
   task automatic write_csr(logic [0:0] idx, logic [15:0] val);
      req_valid <= 1'b0;
      while (alloc_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_RANGE_START) range_lo = val;
      else range_hi = val;
      csr_writes++;
   endtask

   // result side: compare the oldest expectation, then draw the next stall
   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (alloc_expect.size() == 0) begin
            report_mismatch("result with no item pending", '0, rsp_data);
         end else begin
            want = alloc_expect.pop_front();
            status_seen[want.status]++;
            if (rsp_data.status !== want.status || rsp_data.result_id !== want.result_id ||
                rsp_data.is_free !== want.is_free)
               report_mismatch("field differs", want, rsp_data);
         end
      end
      rsp_stall <= long_hold || ($urandom_range(99) < rsp_idle_pct);
   end

   // long receiver hold-off so the block backs up into its input
   initial begin : hold_off
      wait (start_hold);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items still pending",
                  cycle_count, alloc_expect.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      script_row   script [$];
      script_row   row;
      req_type     item;
      logic [15:0] lo_set [PHASES];
      logic [15:0] hi_set [PHASES];
      int          count_set [PHASES];

      // default range first: extremes, every command, clear
      script.push_back(known_row(CMD_CHECK, 16'h0000, STS_OK, 16'h0000, 1'b1));
      script.push_back(known_row(CMD_CHECK, 16'hFFFF, STS_OK, 16'hFFFF, 1'b1));
      script.push_back(known_row(CMD_PEEK, 16'h1234, STS_OK, 16'h0000, 1'b1));
      script.push_back(known_row(CMD_CLAIM_LOW, 16'h1234, STS_OK, 16'h0000, 1'b1));
      script.push_back(known_row(CMD_CLAIM, 16'h0000, STS_TAKEN, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_CLAIM, 16'hFFFF, STS_OK, 16'hFFFF, 1'b1));
      script.push_back(known_row(CMD_CHECK, 16'hFFFF, STS_OK, 16'hFFFF, 1'b0));
      script.push_back(open_row(CMD_PEEK, 16'h0000));
      script.push_back(known_row(CMD_UNUSED_FIRST, 16'hAAAA, STS_OK, 16'hAAAA, 1'b0));
      script.push_back(known_row(CMD_UNUSED_LAST, 16'h5555, STS_OK, 16'h5555, 1'b0));
      script.push_back(known_row(CMD_CLEAR, 16'h00FF, STS_OK, 16'h00FF, 1'b0));
      script.push_back(known_row(CMD_CHECK, 16'hFFFF, STS_OK, 16'hFFFF, 1'b1));
      // start above end: nothing in range, pool counts as empty
      script.push_back(csr_row(CSR_RANGE_START, 16'd100));
      script.push_back(csr_row(CSR_RANGE_END, 16'd99));
      script.push_back(known_row(CMD_CHECK, 16'd100, STS_RANGE, 16'd100, 1'b0));
      script.push_back(known_row(CMD_CLAIM, 16'd100, STS_NO_FREE, 16'd100, 1'b0));
      script.push_back(known_row(CMD_PEEK, 16'h0000, STS_NO_FREE, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_CLAIM_LOW, 16'h0007, STS_NO_FREE, 16'h0000, 1'b0));
      // two ids at the very top, filled up, then the empty-pool orderings
      script.push_back(csr_row(CSR_RANGE_START, 16'hFFFE));
      script.push_back(csr_row(CSR_RANGE_END, 16'hFFFF));
      script.push_back(known_row(CMD_CLAIM, 16'h0005, STS_RANGE, 16'h0005, 1'b0));
      script.push_back(known_row(CMD_CLAIM_LOW, 16'h0000, STS_OK, 16'hFFFE, 1'b1));
      script.push_back(known_row(CMD_CLAIM, 16'hFFFF, STS_OK, 16'hFFFF, 1'b1));
      script.push_back(known_row(CMD_CHECK, 16'hFFFE, STS_NO_FREE, 16'hFFFE, 1'b0));
      script.push_back(known_row(CMD_CLAIM, 16'h0000, STS_NO_FREE, 16'h0000, 1'b0));
      script.push_back(known_row(CMD_PEEK, 16'h0000, STS_NO_FREE, 16'h0000, 1'b0));
      // widening the range keeps the bits already set
      script.push_back(csr_row(CSR_RANGE_START, 16'h0000));
      script.push_back(known_row(CMD_CLAIM, 16'hFFFF, STS_TAKEN, 16'hFFFF, 1'b0));
      script.push_back(open_row(CMD_CHECK, 16'h0001));

      // random phases: small ranges fill up, plus the extremes, a wider range, an empty range and a random one
      lo_set[0] = 16'd197;   hi_set[0] = 16'd287;   count_set[0] = 180;
      lo_set[1] = 16'h0000;  hi_set[1] = 16'd63;    count_set[1] = 180;
      lo_set[2] = 16'hFFC0;  hi_set[2] = 16'hFFFF;  count_set[2] = 180;
      lo_set[3] = 16'($urandom_range(0, 65300));
      hi_set[3] = lo_set[3] + 16'($urandom_range(20, 150));
      count_set[3] = 180;
      lo_set[4] = 16'd1000;  hi_set[4] = 16'd4999;  count_set[4] = 180;
      lo_set[5] = 16'd500;   hi_set[5] = 16'd499;   count_set[5] = 60;
      lo_set[6] = 16'($urandom);
      hi_set[6] = 16'($urandom);
      count_set[6] = 140;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         row = script[i];
         if (row.csr) begin
            write_csr(row.reg_idx, row.val);
         end else begin
            item.cmd = row.cmd;
            item.id  = row.val;
            offer_item(item, row.typed, row.want);
            sender_pause();
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         // idle mix: sender light / receiver heavy, then swapped, then none
         if (p == 2) begin
            req_idle_pct = 81;
            rsp_idle_pct <= 24;
         end
         if (p == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct <= 0;
         end
         write_csr(CSR_RANGE_START, lo_set[p]);
         write_csr(CSR_RANGE_END, hi_set[p]);
         for (int n = 0; n < count_set[p]; n++) begin
            if (p == 4 && n == 20) start_hold = 1'b1;
            offer_item(random_item(), 1'b0, '0);
            sender_pause();
         end
      end

      req_valid <= 1'b0;
      while (alloc_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d commands over %0d range writes, %0d cycles", items_sent, csr_writes,
               cycle_count);
      $display("results ok %0d, taken %0d, out of range %0d, pool empty %0d; %0d mismatches",
               status_seen[STS_OK], status_seen[STS_TAKEN], status_seen[STS_RANGE],
               status_seen[STS_NO_FREE], mismatches);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/idpa_pkg.sv
rtl/idpa_ram.sv
rtl/id_pool_allocator_core.sv
sim/tb_id_pool_allocator_core.sv
